### hw/rtl/sfxd_pkg.sv
`timescale 1ns / 1ps

package sfxd_pkg;

    // Result kinds, as they appear on the output tuser.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_CHKERR  = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // Input kinds, as they appear on the input tuser.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Parser phases.
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_SEEN1   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CHECK   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0] TIMEOUT_RST     = 16'd200;

    localparam int IDX_W = 5;

    // One command handed from the parser to the result generator.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] good;
        logic [31:0] bad;
        logic        link;
    } t_cmd;

endpackage

### hw/rtl/sfxd_ram.sv
`timescale 1ns / 1ps

module sfxd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 28,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sfxd_queue.sv
`timescale 1ns / 1ps

module sfxd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfxd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output sfxd_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import sfxd_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_ent[r_rptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

### hw/rtl/sfxd_front.sv
`timescale 1ns / 1ps

module sfxd_front #(
    parameter int PAYLOAD_BYTES = 28,
    parameter int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [7:0]        i_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output sfxd_pkg::t_cmd    o_cmd,
    input  logic              i_burst_done,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data
);
    import sfxd_pkg::*;

    localparam int FILL_W = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PAYLOAD_BYTES);

    logic [7:0]        r_sync1;
    logic [7:0]        r_sync2;
    logic [15:0]       r_timeout;
    logic [1:0]        r_phase, n_phase;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_xor, n_xor;
    logic [31:0]       r_good, n_good;
    logic [31:0]       r_bad, n_bad;
    logic              r_link, n_link;
    logic [15:0]       r_idle, n_idle;
    logic              r_burst, n_burst;
    logic              accept;

    // While a frame's payload is being read out, the store must not be
    // overwritten, so no new item is taken.
    assign o_ready = !i_q_full && !r_burst;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase   = r_phase;
        n_fill    = r_fill;
        n_xor     = r_xor;
        n_good    = r_good;
        n_bad     = r_bad;
        n_link    = r_link;
        n_idle    = r_idle;
        n_burst   = r_burst;
        o_push    = 1'b0;
        o_wr_en   = 1'b0;
        o_cmd.kind = KIND_PAYLOAD;
        if (i_burst_done) begin
            n_burst = 1'b0;
        end
        if (accept) begin
            if (i_mode == MODE_TICK) begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
                if (r_link && (n_idle > r_timeout)) begin
                    n_link     = 1'b0;
                    o_push     = 1'b1;
                    o_cmd.kind = KIND_TIMEOUT;
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_byte == r_sync1) begin
                            n_phase = PH_SEEN1;
                        end
                    end
                    PH_SEEN1: begin
                        // The second sync byte is tested first, so it wins when
                        // both sync bytes are equal.
                        if (i_byte == r_sync2) begin
                            n_phase = PH_PAYLOAD;
                            n_fill  = '0;
                            n_xor   = 8'd0;
                        end else if (i_byte != r_sync1) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (r_fill < FILL_MAX) begin
                            o_wr_en = 1'b1;
                            n_xor   = r_xor ^ i_byte;
                            n_fill  = r_fill + FILL_W'(1);
                        end
                        if (n_fill >= FILL_MAX) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                        o_push  = 1'b1;
                        if (i_byte == r_xor) begin
                            n_good     = r_good + 32'd1;
                            n_link     = 1'b1;
                            n_idle     = 16'd0;
                            n_burst    = 1'b1;
                            o_cmd.kind = KIND_PAYLOAD;
                        end else begin
                            n_bad      = r_bad + 32'd1;
                            o_cmd.kind = KIND_CHKERR;
                        end
                    end
                endcase
            end
        end
        o_cmd.good = n_good;
        o_cmd.bad  = n_bad;
        o_cmd.link = n_link;
    end

    assign o_wr_addr = r_fill[ADDR_W-1:0];
    assign o_wr_data = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1   <= SYNC_FIRST_RST;
            r_sync2   <= SYNC_SECOND_RST;
            r_timeout <= TIMEOUT_RST;
            r_phase   <= PH_HUNT;
            r_fill    <= '0;
            r_xor     <= 8'd0;
            r_good    <= 32'd0;
            r_bad     <= 32'd0;
            r_link    <= 1'b0;
            r_idle    <= 16'd0;
            r_burst   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_FIRST:  r_sync1   <= i_cfg_data[7:0];
                    CFG_SYNC_SECOND: r_sync2   <= i_cfg_data[7:0];
                    CFG_TIMEOUT:     r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_xor   <= n_xor;
            r_good  <= n_good;
            r_bad   <= n_bad;
            r_link  <= n_link;
            r_idle  <= n_idle;
            r_burst <= n_burst;
        end
    end

endmodule

### hw/rtl/sfxd_back.sv
`timescale 1ns / 1ps

module sfxd_back #(
    parameter int PAYLOAD_BYTES = 28,
    parameter int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfxd_pkg::t_cmd    i_cmd,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output logic              o_burst_done,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_byte,
    output logic [sfxd_pkg::IDX_W-1:0] o_index,
    output logic              o_last,
    output logic [31:0]       o_good,
    output logic [31:0]       o_bad,
    output logic              o_link
);
    import sfxd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(PAYLOAD_BYTES - 1);

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_cmd              r_meta;
    logic              load_meta;
    logic              out_free;
    logic              load_single;
    logic              load_byte;
    logic [ADDR_W+IDX_W-1:0] idx_ext;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [7:0]        r_out_byte;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;
    logic [31:0]       r_out_good;
    logic [31:0]       r_out_bad;
    logic              r_out_link;

    assign out_free = !r_out_valid || i_ready;
    assign idx_ext  = {{IDX_W{1'b0}}, r_idx};

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_pop        = 1'b0;
        o_rd_en      = 1'b0;
        load_meta    = 1'b0;
        load_single  = 1'b0;
        load_byte    = 1'b0;
        o_burst_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.kind == KIND_PAYLOAD) begin
                        o_pop     = 1'b1;
                        load_meta = 1'b1;
                        n_idx     = '0;
                        n_state   = ST_READ;
                    end else if (out_free) begin
                        o_pop       = 1'b1;
                        load_single = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_rd_en = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // The read data holds until the next read, so waiting here
                // for a stalled output is safe.
                if (out_free) begin
                    load_byte = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        o_burst_done = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load_single || load_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_meta) begin
            r_meta <= i_cmd;
        end
        if (load_single) begin
            r_out_kind <= i_cmd.kind;
            r_out_byte <= 8'd0;
            r_out_idx  <= '0;
            r_out_last <= 1'b1;
            r_out_good <= i_cmd.good;
            r_out_bad  <= i_cmd.bad;
            r_out_link <= i_cmd.link;
        end else if (load_byte) begin
            r_out_kind <= KIND_PAYLOAD;
            r_out_byte <= i_rd_data;
            r_out_idx  <= idx_ext[IDX_W-1:0];
            r_out_last <= (r_idx == IDX_LAST);
            r_out_good <= r_meta.good;
            r_out_bad  <= r_meta.bad;
            r_out_link <= r_meta.link;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_byte  = r_out_byte;
    assign o_index = r_out_idx;
    assign o_last  = r_out_last;
    assign o_good  = r_out_good;
    assign o_bad   = r_out_bad;
    assign o_link  = r_out_link;

endmodule

### hw/rtl/sync_frame_xor_deframer.sv
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         tuser: mode; tdata[7:0]: data_byte
// m_axis    out        tuser: kind; tdata: payload_byte, byte_index, good_frames,
//                      bad_frames, link_is_valid; tlast: last
// cfg       in         i_cfg_idx selects sync_first, sync_second, timeout_ticks
//
// A checksum error or timeout result passes through the command queue into the
// output register. A good frame's payload is read back from the payload RAM one
// byte at a time, each through a read state and then a load state that waits while
// the output is stalled, and no input is taken from the checksum transfer until the
// last byte has been loaded into the output register.
// Reset is synchronous; the payload RAM is not cleared. Output stalls back up
// into the two-entry command queue and then into s_axis tready.
module sync_frame_xor_deframer #(
    parameter int PAYLOAD_BYTES = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] payload_byte, [12:8] byte_index, [44:13] good_frames,
    // [76:45] bad_frames, [77] link_is_valid, [79:78] zero
    output logic [79:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast
);
    import sfxd_pkg::*;

    localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    t_cmd              push_cmd;
    t_cmd              head_cmd;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              burst_done;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [7:0]        out_byte;
    logic [IDX_W-1:0]  out_idx;
    logic [31:0]       out_good;
    logic [31:0]       out_bad;
    logic              out_link;

    sfxd_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_mode       (i_s_axis_tuser),
        .i_byte       (i_s_axis_tdata),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_burst_done (burst_done),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    sfxd_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    sfxd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sfxd_back #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_burst_done (burst_done),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_kind       (o_m_axis_tuser),
        .o_byte       (out_byte),
        .o_index      (out_idx),
        .o_last       (o_m_axis_tlast),
        .o_good       (out_good),
        .o_bad        (out_bad),
        .o_link       (out_link)
    );

    assign o_m_axis_tdata = {2'b00, out_link, out_bad, out_good, out_idx, out_byte};

endmodule

### sim/sync_frame_xor_deframer_tb.sv
`timescale 1ns / 1ps

import sfxd_pkg::*;

localparam int FRAME_LEN = 28;

typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [4:0]  index;
    logic        last;
    logic [31:0] good;
    logic [31:0] bad;
    logic        link;
} t_deframe_result;

class deframe_scoreboard;
    t_deframe_result due_results[$];
    int unsigned     mismatches;

    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] timeout_ticks;

    logic [1:0]  phase;
    logic [7:0]  frame_bytes[FRAME_LEN];
    logic [4:0]  fill;
    logic [7:0]  xor_acc;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
    logic        link_up;
    logic [15:0] idle_ticks;

    function new();
        sync_first    = SYNC_FIRST_RST;
        sync_second   = SYNC_SECOND_RST;
        timeout_ticks = TIMEOUT_RST;
        phase         = PH_HUNT;
        fill          = '0;
        xor_acc       = '0;
        good_cnt      = '0;
        bad_cnt       = '0;
        link_up       = 1'b0;
        idle_ticks    = '0;
        mismatches    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
        case (idx)
            CFG_SYNC_FIRST:  sync_first = value[7:0];
            CFG_SYNC_SECOND: sync_second = value[7:0];
            CFG_TIMEOUT:     timeout_ticks = value;
            default: ;
        endcase
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] payload, logic [4:0] index,
                              logic last);
        t_deframe_result r;
        r.kind    = kind;
        r.payload = payload;
        r.index   = index;
        r.last    = last;
        r.good    = good_cnt;
        r.bad     = bad_cnt;
        r.link    = link_up;
        due_results.push_back(r);
    endfunction

    // Advances the parser by one accepted input transfer and queues what it emits.
    function void parse_item(logic mode, logic [7:0] b);
        if (mode == MODE_TICK) begin
            if (idle_ticks != 16'hFFFF)
                idle_ticks = idle_ticks + 16'd1;
            if (link_up && idle_ticks > timeout_ticks) begin
                link_up = 1'b0;
                push_result(KIND_TIMEOUT, 8'h00, 5'd0, 1'b1);
            end
            return;
        end
        case (phase)
            PH_HUNT: begin
                if (b == sync_first)
                    phase = PH_SEEN1;
            end
            PH_SEEN1: begin
                // The second sync byte is tested first, so equal sync bytes start a frame.
                if (b == sync_second) begin
                    phase   = PH_PAYLOAD;
                    fill    = '0;
                    xor_acc = '0;
                end else if (b != sync_first) begin
                    phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                if (fill < FRAME_LEN) begin
                    frame_bytes[fill] = b;
                    xor_acc = xor_acc ^ b;
                    fill = fill + 5'd1;
                end
                if (fill >= FRAME_LEN)
                    phase = PH_CHECK;
            end
            default: begin
                phase = PH_HUNT;
                if (xor_acc == b) begin
                    good_cnt   = good_cnt + 32'd1;
                    link_up    = 1'b1;
                    idle_ticks = '0;
                    for (int i = 0; i < FRAME_LEN; i++)
                        push_result(KIND_PAYLOAD, frame_bytes[i], 5'(i), i == FRAME_LEN - 1);
                end else begin
                    bad_cnt = bad_cnt + 32'd1;
                    push_result(KIND_CHKERR, 8'h00, 5'd0, 1'b1);
                end
            end
        endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [79:0] data, logic last);
        t_deframe_result e;
        if (due_results.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected output transfer: kind %0d tdata %h last %0d",
                         kind, data, last);
            mismatches++;
            return;
        end
        e = due_results.pop_front();
        if (kind !== e.kind || data[7:0] !== e.payload || data[12:8] !== e.index ||
            data[44:13] !== e.good || data[76:45] !== e.bad || data[77] !== e.link ||
            data[79:78] !== 2'b00 || last !== e.last) begin
            if (mismatches < 10)
                $display({"output mismatch: expected kind %0d byte %h idx %0d last %0d ",
                          "good %0d bad %0d link %0d pad 0; got kind %0d byte %h idx %0d ",
                          "last %0d good %0d bad %0d link %0d pad %0d"},
                         e.kind, e.payload, e.index, e.last, e.good, e.bad, e.link,
                         kind, data[7:0], data[12:8], last, data[44:13], data[76:45],
                         data[77], data[79:78]);
            mismatches++;
        end
    endfunction

    function void check_drained();
        if (due_results.size() != 0) begin
            if (mismatches < 10)
                $display("%0d expected output transfers never arrived", due_results.size());
            mismatches++;
        end
    endfunction
endclass

module sync_frame_xor_deframer_tb;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_idx  = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid  = 1'b0;
    logic [7:0]  s_data   = '0;
    logic        s_user   = 1'b0;
    logic        m_ready  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [79:0] m_data;
    logic [1:0]  m_user;
    logic        m_last;

    deframe_scoreboard sb = new();

    int burst_left  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_style = 0;
    int stall_phase = 0;

    sync_frame_xor_deframer #(
        .PAYLOAD_BYTES(FRAME_LEN)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure: switches between always ready, random, mostly stalled
    // and a fixed repeating pattern from stall_phase.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(32, 400);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_phase % 3 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            sb.check_result(m_user, m_data, m_last);
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sync_frame_xor_deframer_tb failed");
            $finish;
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= b;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.parse_item(mode, b);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(MODE_BYTE, b);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    // style: 0 random, 1 alternating 00/FF, 2 sync values mixed in, 3 all FF.
    task automatic send_frame(input int style, input int extra_first, input bit corrupt);
        logic [7:0] body[FRAME_LEN];
        logic [7:0] sum;
        int pick;
        sum = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            pick = $urandom_range(0, 2);
            case (style)
                0: body[i] = 8'($urandom_range(0, 255));
                1: body[i] = (i % 2 != 0) ? 8'hFF : 8'h00;
                2: body[i] = (pick == 0) ? sb.sync_first :
                             (pick == 1) ? sb.sync_second : 8'($urandom_range(0, 255));
                default: body[i] = 8'hFF;
            endcase
            sum = sum ^ body[i];
        end
        send_byte(sb.sync_first);
        repeat (extra_first) send_byte(sb.sync_first);
        send_byte(sb.sync_second);
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(body[i]);
        send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    // Drops tvalid and waits until every predicted transfer has come out.
    task automatic settle();
        @(negedge i_clk);
        s_valid    <= 1'b0;
        burst_left = 0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [7:0] first, input logic [7:0] second,
                                  input logic [15:0] tmo);
        settle();
        // Upper bits of the 8-bit registers carry junk that must be dropped.
        write_reg(CFG_SYNC_FIRST, {8'($urandom_range(0, 255)), first});
        write_reg(CFG_SYNC_SECOND, {8'($urandom_range(0, 255)), second});
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    task automatic random_traffic(input int budget);
        int stop_at;
        int pick;
        int extra;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pick  = $urandom_range(0, 99);
            extra = (sb.sync_first != sb.sync_second) ? $urandom_range(0, 2) : 0;
            if (pick < 45) begin
                send_frame($urandom_range(0, 3), extra, 1'b0);
            end else if (pick < 58) begin
                send_frame($urandom_range(0, 3), extra, 1'b1);
            end else if (pick < 68) begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 80) begin
                send_ticks($urandom_range(1, 12));
            end else if (pick < 90) begin
                // Header that breaks off after the first sync byte.
                repeat ($urandom_range(1, 3)) send_byte(sb.sync_first);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                // Frame cut short; whatever follows is taken as its payload.
                send_byte(sb.sync_first);
                send_byte(sb.sync_second);
                repeat ($urandom_range(1, FRAME_LEN - 1))
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: hunt edge cases, then a good and a bad frame.
        send_ticks(1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST_RST);
        send_byte(8'h13);
        send_frame(1, 2, 1'b0);
        send_frame(3, 0, 1'b1);
        send_ticks(3);

        // Zero timeout drops the link on the first tick.
        apply_settings(8'h00, 8'hFF, 16'd0);
        send_frame(0, 0, 1'b0);
        send_ticks(2);

        // Equal sync bytes, and the largest timeout, which these ticks never pass.
        apply_settings(8'h3C, 8'h3C, 16'hFFFF);
        send_frame(2, 0, 1'b0);
        send_ticks(4);

        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(1, 12)));
        random_traffic(25);

        apply_settings(8'hFF, 8'h00, 16'd1);
        random_traffic(15);

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("sync_frame_xor_deframer_tb passed");
        else
            $display("sync_frame_xor_deframer_tb failed");
        $finish;
    end

endmodule
